/* hdl/hrte_pkg.sv */
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// hrte_pkg
// Types, codes and a helper function shared by the HEX record text encoder.
// ----------------------------------------------------------------------------
package hrte_pkg;

	typedef enum logic [1:0] {
		ACT_BEGIN = 2'd0,
		ACT_DATA  = 2'd1,
		ACT_END   = 2'd2
	} action_t;

	localparam logic [6:0] CHAR_COLON = 7'h3A;
	localparam logic [6:0] CHAR_ZERO  = 7'h30;
	localparam logic [3:0] HDR_LAST   = 4'd8;
	localparam logic [3:0] BYTE_LAST  = 4'd1;

	typedef struct packed {
		logic        is_hdr;
		logic [23:0] body;
		logic        done;
	} entry_t;

	function automatic logic [6:0] hex_char(input logic [3:0] nib);
		logic [6:0] wide;
		wide = {3'b000, nib};
		hex_char = (nib < 4'd10) ? (CHAR_ZERO + wide) : (7'h37 + wide);
	endfunction

endpackage
`default_nettype wire

/* hdl/hrte_front.sv */
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// hrte_front
// Accepts requests, keeps the running checksum and queues one work entry per
// request that produces characters.
// ----------------------------------------------------------------------------
module hrte_front import hrte_pkg::*; (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        in_valid,
	output logic             in_ready,
	input  wire logic [1:0]  action,
	input  wire logic [7:0]  record_length,
	input  wire logic [15:0] load_address,
	input  wire logic [7:0]  data_byte,
	output logic             push,
	output entry_t           push_entry,
	input  wire logic        queue_ready
);

	logic [7:0] sum_q;
	logic       accept;

	assign in_ready = queue_ready;
	assign accept   = in_valid && in_ready;

	always_comb begin
		push       = 1'b0;
		push_entry = '{is_hdr: 1'b0, body: 24'd0, done: 1'b0};
		case (action_t'(action))
			ACT_BEGIN: begin
				push       = accept;
				push_entry = '{is_hdr: 1'b1, body: {record_length, load_address}, done: 1'b0};
			end
			ACT_DATA: begin
				push       = accept;
				push_entry = '{is_hdr: 1'b0, body: {16'd0, data_byte}, done: 1'b0};
			end
			ACT_END: begin
				push       = accept;
				push_entry = '{is_hdr: 1'b0, body: {16'd0, 8'd0 - sum_q}, done: 1'b1};
			end
			default: begin
				push = 1'b0;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			sum_q <= 8'd0;
		end else if (accept) begin
			case (action_t'(action))
				ACT_BEGIN: sum_q <= record_length + load_address[15:8] + load_address[7:0];
				ACT_DATA:  sum_q <= sum_q + data_byte;
				default:   sum_q <= sum_q;
			endcase
		end
	end

endmodule
`default_nettype wire

/* hdl/hrte_queue.sv */
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// hrte_queue
// Small first-in first-out queue of work entries between front and back.
// ----------------------------------------------------------------------------
module hrte_queue import hrte_pkg::*; #(
	parameter int DEPTH = 4
) (
	input  wire logic clk,
	input  wire logic arst_n,
	input  wire logic push,
	input  entry_t    push_entry,
	output logic      push_ready,
	input  wire logic pop,
	output entry_t    pop_entry,
	output logic      pop_valid
);

	localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CW = $clog2(DEPTH + 1);
	localparam logic [PW-1:0] PTR_LAST = PW'(DEPTH - 1);
	localparam logic [CW-1:0] CNT_FULL = CW'(DEPTH);

	entry_t        mem_q [DEPTH];
	logic [PW-1:0] wr_ptr_q;
	logic [PW-1:0] rd_ptr_q;
	logic [CW-1:0] count_q;
	logic          do_push;
	logic          do_pop;

	assign push_ready = (count_q != CNT_FULL);
	assign pop_valid  = (count_q != '0);
	assign pop_entry  = mem_q[rd_ptr_q];
	assign do_push    = push && push_ready;
	assign do_pop     = pop && pop_valid;

	always_ff @(posedge clk) begin
		if (do_push) begin
			mem_q[wr_ptr_q] <= push_entry;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (do_push) begin
				wr_ptr_q <= (wr_ptr_q == PTR_LAST) ? '0 : wr_ptr_q + 1'b1;
			end
			if (do_pop) begin
				rd_ptr_q <= (rd_ptr_q == PTR_LAST) ? '0 : rd_ptr_q + 1'b1;
			end
			case ({do_push, do_pop})
				2'b10:   count_q <= count_q + 1'b1;
				2'b01:   count_q <= count_q - 1'b1;
				default: count_q <= count_q;
			endcase
		end
	end

endmodule
`default_nettype wire

/* hdl/hrte_back.sv */
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// hrte_back
// Serializes queued entries into ASCII characters, one per cycle while not
// stalled by out_ready, through a registered output stage.
// ----------------------------------------------------------------------------
module hrte_back import hrte_pkg::*; (
	input  wire logic       clk,
	input  wire logic       arst_n,
	input  entry_t          pop_entry,
	input  wire logic       pop_valid,
	output logic            pop,
	output logic            out_valid,
	input  wire logic       out_ready,
	output logic [6:0]      ascii_char,
	output logic            record_done
);

	entry_t     cur_q;
	logic       busy_q;
	logic [3:0] idx_q;
	logic       out_valid_q;
	logic [6:0] char_q;
	logic       done_q;
	logic       advance;
	logic       last;
	logic [3:0] nib;
	logic [6:0] char_next;
	logic       done_next;

	assign advance = !out_valid_q || out_ready;
	assign last    = (idx_q == (cur_q.is_hdr ? HDR_LAST : BYTE_LAST));
	assign pop     = pop_valid && (!busy_q || (advance && last));

	always_comb begin
		nib = 4'd0;
		if (cur_q.is_hdr) begin
			case (idx_q)
				4'd1:    nib = cur_q.body[23:20];
				4'd2:    nib = cur_q.body[19:16];
				4'd3:    nib = cur_q.body[15:12];
				4'd4:    nib = cur_q.body[11:8];
				4'd5:    nib = cur_q.body[7:4];
				4'd6:    nib = cur_q.body[3:0];
				default: nib = 4'd0;
			endcase
			char_next = (idx_q == 4'd0) ? CHAR_COLON : hex_char(nib);
			done_next = 1'b0;
		end else begin
			nib       = (idx_q == 4'd0) ? cur_q.body[7:4] : cur_q.body[3:0];
			char_next = hex_char(nib);
			done_next = cur_q.done && (idx_q == BYTE_LAST);
		end
	end

	always_ff @(posedge clk) begin
		if (pop) begin
			cur_q <= pop_entry;
		end
		if (advance && busy_q) begin
			char_q <= char_next;
			done_q <= done_next;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q      <= 1'b0;
			idx_q       <= 4'd0;
			out_valid_q <= 1'b0;
		end else begin
			if (advance) begin
				out_valid_q <= busy_q;
			end
			if (!busy_q) begin
				busy_q <= pop_valid;
				idx_q  <= 4'd0;
			end else if (advance) begin
				if (last) begin
					busy_q <= pop_valid;
					idx_q  <= 4'd0;
				end else begin
					idx_q <= idx_q + 1'b1;
				end
			end
		end
	end

	assign out_valid   = out_valid_q;
	assign ascii_char  = char_q;
	assign record_done = done_q;

endmodule
`default_nettype wire

/* hdl/hex_record_text_encoder.sv */
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// hex_record_text_encoder
// Intel HEX data record encoder producing one ASCII character per result.
// ----------------------------------------------------------------------------
// Each request is classified at the input, which also keeps the running
// checksum, and is queued for the serializer. The serializer emits one
// character per clock while out_ready is high, so a begin request yields nine
// characters and a data or end request two; action code 3 is dropped and yields none.
// Requests are accepted while the queue has room, QUEUE_DEPTH entries
// ahead of the character being shown. The output register sets the
// sustained rate of one character per cycle while out_ready is high.
module hex_record_text_encoder import hrte_pkg::*; #(
	parameter int QUEUE_DEPTH = 4
) (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        in_valid,
	output logic             in_ready,
	input  wire logic [1:0]  action,
	input  wire logic [7:0]  record_length,
	input  wire logic [15:0] load_address,
	input  wire logic [7:0]  data_byte,
	output logic             out_valid,
	input  wire logic        out_ready,
	output logic [6:0]       ascii_char,
	output logic             record_done
);

	logic   push;
	entry_t push_entry;
	logic   queue_ready;
	logic   pop;
	entry_t pop_entry;
	logic   pop_valid;

	hrte_front u_front (
		.clk          (clk),
		.arst_n       (arst_n),
		.in_valid     (in_valid),
		.in_ready     (in_ready),
		.action       (action),
		.record_length(record_length),
		.load_address (load_address),
		.data_byte    (data_byte),
		.push         (push),
		.push_entry   (push_entry),
		.queue_ready  (queue_ready)
	);

	hrte_queue #(
		.DEPTH(QUEUE_DEPTH)
	) u_queue (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (push),
		.push_entry(push_entry),
		.push_ready(queue_ready),
		.pop       (pop),
		.pop_entry (pop_entry),
		.pop_valid (pop_valid)
	);

	hrte_back u_back (
		.clk        (clk),
		.arst_n     (arst_n),
		.pop_entry  (pop_entry),
		.pop_valid  (pop_valid),
		.pop        (pop),
		.out_valid  (out_valid),
		.out_ready  (out_ready),
		.ascii_char (ascii_char),
		.record_done(record_done)
	);

endmodule
`default_nettype wire

/* hdl/hrte_checker.sv */
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// hrte_checker
// Port-level checks for the HEX record text encoder, bound to the top level.
// ----------------------------------------------------------------------------
module hrte_checker import hrte_pkg::*; (
	input wire logic       clk,
	input wire logic       arst_n,
	input wire logic       out_valid,
	input wire logic       out_ready,
	input wire logic [6:0] ascii_char,
	input wire logic       record_done
);

	logic is_hex;

	assign is_hex = (ascii_char >= 7'h30 && ascii_char <= 7'h39) ||
		(ascii_char >= 7'h41 && ascii_char <= 7'h46);

	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(ascii_char) && $stable(record_done))
		else $error("Stalled output changed.");

	a_char_set: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> is_hex || ascii_char == CHAR_COLON)
		else $error("Output character is neither a colon nor a hex digit.");

	a_done_hex: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && record_done |-> is_hex)
		else $error("Record end marked on a non-digit character.");

	a_colon_follow: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_ready && ascii_char == CHAR_COLON |=> !(out_valid && record_done))
		else $error("Record end marked right after a colon.");

endmodule

bind hex_record_text_encoder hrte_checker u_hrte_checker (
	.clk        (clk),
	.arst_n     (arst_n),
	.out_valid  (out_valid),
	.out_ready  (out_ready),
	.ascii_char (ascii_char),
	.record_done(record_done)
);
`default_nettype wire
